@@ rtl/skt_pkg.sv @@
// Shared types, codes and defaults for the sorted key table.
package skt_pkg;

  // Default number of table entries.
  localparam int CAPACITY_DEF = 64;

  // Operation codes; the high bit of op selects a clear.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam int         OP_CLEAR_BIT = 1;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_DELETED   = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_CLEARED   = 3'd5;

  // One request.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] weight;
  } in_t;

  // One result.
  typedef struct packed {
    status_t            status;
    logic [6:0]         entry_count;
    logic signed [31:0] removed_weight;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    step;
    logic    wr_new;
    logic    wr_carry;
    logic    wr_shift;
    logic    carry_ld;
    logic    status_ld;
    status_t status;
    logic    save_removed;
    logic    finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic is_insert;
    logic at_end;
    logic last;
    logic less;
    logic match;
    logic full;
    logic out_free;
  } ctl_sts_t;

endpackage

@@ rtl/sorted_key_table.sv @@
// Top level of the sorted key table: ascending signed keys with weights.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   in_t  {op, key, weight}
//   out_      output     out_valid / out_ready out_t {status, entry_count, removed_weight}
//
// Insert and delete walk the entry RAM once, at most one read and one write per
// cycle; the next request can be accepted once the result is registered.
// Clear goes straight to its result without walking the entries.
// Reset (rst_n, synchronous) empties the table; the RAM itself is not cleared.
// A stalled result sits in the output register; the next request is accepted
// meanwhile and its result is held in status_r until the register is free.
module sorted_key_table import skt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  skt_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/skt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/skt_ctl.sv @@
// Controller state machine for the sorted key table.
module skt_ctl import skt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_INS  = 5'b00100,
    S_DEL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.is_clear) begin
          cmd.status_ld = 1'b1;
          cmd.status    = ST_CLEARED;
          state_nxt     = S_DONE;
        end else if (!sts.at_end && sts.less) begin
          // Still below the request key: keep walking.
          cmd.step = 1'b1;
        end else if (sts.is_insert) begin
          cmd.status_ld = 1'b1;
          if (!sts.at_end && sts.match) begin
            cmd.status = ST_DUPLICATE;
            state_nxt  = S_DONE;
          end else if (sts.full) begin
            cmd.status = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            // Place the new entry and carry the displaced one upward.
            cmd.status   = ST_INSERTED;
            cmd.wr_new   = 1'b1;
            cmd.carry_ld = 1'b1;
            if (sts.at_end) begin
              state_nxt = S_DONE;
            end else begin
              cmd.step  = 1'b1;
              state_nxt = S_INS;
            end
          end
        end else begin
          cmd.status_ld = 1'b1;
          if (sts.at_end || !sts.match) begin
            cmd.status = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            cmd.status       = ST_DELETED;
            cmd.save_removed = 1'b1;
            if (sts.last) begin
              state_nxt = S_DONE;
            end else begin
              cmd.step  = 1'b1;
              state_nxt = S_DEL;
            end
          end
        end
      end
      S_INS: begin
        cmd.wr_carry = 1'b1;
        cmd.carry_ld = 1'b1;
        if (sts.at_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DEL: begin
        cmd.wr_shift = 1'b1;
        if (sts.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one RAM write source is selected in any cycle.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_new, cmd.wr_carry, cmd.wr_shift}))
    else $error("more than one RAM write source selected");

  // A result is only committed when the output register can take it.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result committed while output register is occupied");

  // After a request is taken the controller always goes to the walk.
  a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SCAN))
    else $error("accepted request did not start a walk");

endmodule

@@ rtl/skt_dp.sv @@
// Datapath for the sorted key table: entry RAM, walk index, count and result.
module skt_dp import skt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  logic     out_ready,
  output logic     out_valid,
  output out_t     out_data,
  input  ctl_cmd_t cmd,
  output ctl_sts_t sts
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  in_t              req_r;
  logic [CW-1:0]    idx_r, idx_nxt, idx_inc, idx_dec;
  logic [CW-1:0]    count_r, count_nxt;
  logic [63:0]      carry_r;
  status_t          status_r;
  logic [31:0]      removed_r;
  out_t             out_r;
  logic             out_valid_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [63:0]      wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [63:0]      rd_data;
  logic [31:0]      rd_key;

  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign rd_key  = rd_data[63:32];

  // Walk index: restarts at zero on a new request, advances on a step.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_inc;
    end
  end

  // The read always runs one entry ahead of the index.
  assign rd_en   = cmd.load | cmd.step;
  assign rd_addr = cmd.load ? '0 : idx_inc[AW-1:0];

  // Write selection: new entry, carried entry, or an entry moved down.
  assign wr_en   = cmd.wr_new | cmd.wr_carry | cmd.wr_shift;
  assign wr_addr = cmd.wr_shift ? idx_dec[AW-1:0] : idx_r[AW-1:0];
  always_comb begin
    if (cmd.wr_new) begin
      wr_data = {req_r.key, req_r.weight};
    end else if (cmd.wr_carry) begin
      wr_data = carry_r;
    end else begin
      wr_data = rd_data;
    end
  end

  skt_ram #(
    .WIDTH (64),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status back to the controller.
  assign sts.is_clear  = req_r.op[OP_CLEAR_BIT];
  assign sts.is_insert = (req_r.op == OP_INSERT);
  assign sts.at_end    = (idx_r == count_r);
  assign sts.last      = (idx_inc == count_r);
  assign sts.less      = ($signed(rd_key) < req_r.key);
  assign sts.match     = (rd_key == req_r.key);
  assign sts.full      = (count_r == CW'(CAPACITY));
  assign sts.out_free  = !out_valid_r || out_ready;

  // Entry count after the finished operation.
  always_comb begin
    case (status_r)
      ST_INSERTED: count_nxt = count_r + CW'(1);
      ST_DELETED:  count_nxt = count_r - CW'(1);
      ST_CLEARED:  count_nxt = '0;
      default:     count_nxt = count_r;
    endcase
  end

  // Request, walk and result payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      req_r     <= in_data;
      removed_r <= '0;
    end else if (cmd.save_removed) begin
      removed_r <= rd_data[31:0];
    end
    if (cmd.carry_ld) begin
      carry_r <= rd_data;
    end
    if (cmd.status_ld) begin
      status_r <= cmd.status;
    end
    if (cmd.finish) begin
      out_r.status         <= status_r;
      out_r.entry_count    <= 7'(count_nxt);
      out_r.removed_weight <= removed_r;
    end
  end

  // Control state: entry count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A full refusal only happens on a table at capacity.
  a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && status_r == ST_FULL) |-> sts.full)
    else $error("full reported on a table below capacity");

  // Refused requests leave the count alone.
  a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (status_r == ST_DUPLICATE || status_r == ST_NOT_FOUND ||
                    status_r == ST_FULL)) |=> $stable(count_r))
    else $error("refused request changed the entry count");

endmodule
